// ===== design/hcd_pkg.sv =====
// Package for the 4x4 Hill cipher decrypt block.
// Holds the shared widths, key reset values, register indexes, payload types and the mod-26 helper.
// No dependencies.
package hcd_pkg;

	localparam int unsigned KEY_ROWS    = 4;
	localparam int unsigned LETTER_W    = 5;
	localparam int unsigned ROW_W       = KEY_ROWS * LETTER_W;
	localparam int unsigned CHAR_W      = 8;
	localparam int unsigned PLAIN_W     = 7;
	localparam int unsigned SUM_W       = 12;
	localparam int unsigned PROD_W      = 2 * SUM_W;
	localparam int unsigned RECIP_SHIFT = 16;
	localparam int unsigned QUOT_W      = PROD_W - RECIP_SHIFT;
	localparam int unsigned QUEUE_DEPTH = 8;

	localparam logic [SUM_W-1:0]   MODULUS = SUM_W'(26);
	// floor(x/26) == (x * 2521) >> 16 for every 12-bit x
	localparam logic [PROD_W-1:0]  RECIP   = PROD_W'(2521);
	localparam logic [CHAR_W-1:0]  ASCII_A = CHAR_W'(65);
	localparam logic [CHAR_W-1:0]  ASCII_Z = CHAR_W'(90);
	localparam logic [PLAIN_W-1:0] PLAIN_A = PLAIN_W'(65);

	localparam logic [ROW_W-1:0] INV_KEY_ROW0_RST = ROW_W'(543928);
	localparam logic [ROW_W-1:0] INV_KEY_ROW1_RST = ROW_W'(230514);
	localparam logic [ROW_W-1:0] INV_KEY_ROW2_RST = ROW_W'(332468);
	localparam logic [ROW_W-1:0] INV_KEY_ROW3_RST = ROW_W'(807279);

	localparam int unsigned CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INV_KEY_ROW0 = 2'd0,
		REG_INV_KEY_ROW1 = 2'd1,
		REG_INV_KEY_ROW2 = 2'd2,
		REG_INV_KEY_ROW3 = 2'd3
	} cfg_reg_t;

	typedef logic [KEY_ROWS-1:0][ROW_W-1:0] key_t;

	// one block result: either an error or four plaintext letter values
	typedef struct packed {
		logic                               bad;
		logic [KEY_ROWS-1:0][LETTER_W-1:0] letters;
	} grp_t;

	// pipeline occupancy, used for the input credit check
	typedef struct packed {
		logic busy_s1;
		logic busy_s2;
	} pipe_stat_t;

	function automatic logic [LETTER_W-1:0] mod26(input logic [SUM_W-1:0] x);
		logic [PROD_W-1:0] prod;
		logic [QUOT_W-1:0] q;
		logic [SUM_W-1:0]  r;
		prod = PROD_W'(x) * RECIP;
		q    = prod[PROD_W-1:RECIP_SHIFT];
		r    = x - SUM_W'(q) * MODULUS;
		if (r >= MODULUS) begin
			r = r - MODULUS;
		end
		return r[LETTER_W-1:0];
	endfunction

endpackage

// ===== design/hcd_if.sv =====
// Valid/ready stream interfaces for the Hill cipher decrypt block.
// Depends on hcd_pkg for field widths.
interface hcd_char_if;
	logic                        valid;
	logic                        ready;
	logic [hcd_pkg::CHAR_W-1:0] cipher_char;

	modport source (output valid, output cipher_char, input ready);
	modport sink   (input valid, input cipher_char, output ready);
endinterface

interface hcd_result_if;
	logic                         valid;
	logic                         ready;
	logic [hcd_pkg::PLAIN_W-1:0] plain_char;
	logic                         bad_char;
	logic                         block_end;

	modport source (output valid, output plain_char, output bad_char, output block_end,
		input ready);
	modport sink   (input valid, input plain_char, input bad_char, input block_end,
		output ready);
endinterface

// ===== design/hcd_block_math.sv =====
// Letter buffering, key matrix product (stage 1) and mod-26 reduction (stage 2).
// Emits one result group per completed block or bad character. Depends on hcd_pkg.
module hcd_block_math (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        take,
	input  logic [hcd_pkg::CHAR_W-1:0] char_in,
	input  hcd_pkg::key_t               key,
	output hcd_pkg::pipe_stat_t         stat,
	output logic                        grp_valid,
	output hcd_pkg::grp_t               grp
);

	logic                          valid_s1;
	logic [hcd_pkg::CHAR_W-1:0]   char_s1;
	logic [1:0]                    fill_q;
	logic [hcd_pkg::LETTER_W-1:0] buf_q [3];

	logic                          valid_s2;
	logic                          bad_s2;
	logic [hcd_pkg::SUM_W-1:0]    sum_s2 [hcd_pkg::KEY_ROWS];

	logic                          is_letter;
	logic                          blk_done;
	logic [hcd_pkg::LETTER_W-1:0] letter;
	logic [hcd_pkg::SUM_W-1:0]    sum_c [hcd_pkg::KEY_ROWS];

	assign is_letter = (char_s1 >= hcd_pkg::ASCII_A) && (char_s1 <= hcd_pkg::ASCII_Z);
	assign letter    = hcd_pkg::LETTER_W'(char_s1 - hcd_pkg::ASCII_A);
	assign blk_done  = valid_s1 && is_letter && (fill_q == 2'd3);

	always_comb begin
		logic [hcd_pkg::LETTER_W-1:0] blk [hcd_pkg::KEY_ROWS];
		logic [hcd_pkg::SUM_W-1:0]    acc;
		blk[0] = buf_q[0];
		blk[1] = buf_q[1];
		blk[2] = buf_q[2];
		blk[3] = letter;
		for (int r = 0; r < hcd_pkg::KEY_ROWS; r++) begin
			acc = '0;
			for (int c = 0; c < hcd_pkg::KEY_ROWS; c++) begin
				acc = acc + hcd_pkg::SUM_W'(key[r][c*hcd_pkg::LETTER_W +: hcd_pkg::LETTER_W])
					* hcd_pkg::SUM_W'(blk[c]);
			end
			sum_c[r] = acc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			valid_s1 <= take;
			valid_s2 <= valid_s1 && (!is_letter || (fill_q == 2'd3));
			if (valid_s1 && is_letter) begin
				fill_q <= fill_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			char_s1 <= char_in;
		end
		if (valid_s1 && is_letter && (fill_q != 2'd3)) begin
			buf_q[fill_q] <= letter;
		end
		if (valid_s1) begin
			bad_s2 <= !is_letter;
		end
		if (blk_done) begin
			sum_s2 <= sum_c;
		end
	end

	assign stat.busy_s1 = valid_s1;
	assign stat.busy_s2 = valid_s2;
	assign grp_valid    = valid_s2;

	always_comb begin
		grp.bad = bad_s2;
		for (int r = 0; r < hcd_pkg::KEY_ROWS; r++) begin
			grp.letters[r] = hcd_pkg::mod26(sum_s2[r]);
		end
	end

endmodule

// ===== design/hcd_result_queue.sv =====
// Result group queue and serializer: stores groups, sends one result per transfer.
// An error group yields one result, a letter group four. Depends on hcd_pkg, hcd_if.
module hcd_result_queue #(
	parameter int unsigned Depth = hcd_pkg::QUEUE_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        grp_valid,
	input  hcd_pkg::grp_t               grp,
	output logic [$clog2(Depth+1)-1:0] count,
	hcd_result_if.source                plain
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

	hcd_pkg::grp_t   mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic [1:0]      sub_q;

	hcd_pkg::grp_t   head;
	logic            xfer;
	logic            pop;

	assign head  = mem_q[rd_ptr_q];
	assign xfer  = plain.valid && plain.ready;
	assign pop   = xfer && plain.block_end;
	assign count = count_q;

	assign plain.valid      = (count_q != '0);
	assign plain.bad_char   = head.bad;
	assign plain.block_end  = head.bad || (sub_q == 2'd3);
	assign plain.plain_char = head.bad ? '0
		: hcd_pkg::PLAIN_A + hcd_pkg::PLAIN_W'(head.letters[sub_q]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			sub_q    <= 2'd0;
		end else begin
			if (grp_valid) begin
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
				sub_q    <= 2'd0;
			end else if (xfer) begin
				sub_q <= sub_q + 2'd1;
			end
			if (grp_valid && !pop) begin
				count_q <= count_q + CntW'(1);
			end else if (pop && !grp_valid) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (grp_valid) begin
			mem_q[wr_ptr_q] <= grp;
		end
	end

endmodule

// ===== design/hill_cipher_decrypt_4x4.sv =====
// Hill cipher 4x4 mod-26 decrypt, top level. Depends on hcd_pkg, hcd_if and submodules.
// Accepts one character per cycle while cipher.ready is high; a letter that completes a
// block of four passes stage 1 and stage 2 into the group queue as four results; a bad
// character gives one. The result port sets the rate: one result per cycle while ready.
// Reset clears the letter count and queue and loads the default inverse key.
module hill_cipher_decrypt_4x4 #(
	parameter int unsigned QueueDepth = hcd_pkg::QUEUE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	hcd_char_if.sink                       cipher,
	hcd_result_if.source                   plain,
	input  logic                           cfg_we,
	input  logic [hcd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hcd_pkg::ROW_W-1:0]     cfg_wdata
);

	localparam int unsigned CntW = $clog2(QueueDepth + 1);

	hcd_pkg::key_t       key_q;
	hcd_pkg::pipe_stat_t stat;
	hcd_pkg::grp_t       grp;
	logic                grp_valid;
	logic [CntW-1:0]     q_count;
	logic [CntW:0]       committed;
	logic                take;

	// credit: every item in flight may still become a queued group
	assign committed    = (CntW+1)'(q_count) + (CntW+1)'(stat.busy_s1)
		+ (CntW+1)'(stat.busy_s2);
	assign cipher.ready = committed < (CntW+1)'(QueueDepth);
	assign take         = cipher.valid && cipher.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q[0] <= hcd_pkg::INV_KEY_ROW0_RST;
			key_q[1] <= hcd_pkg::INV_KEY_ROW1_RST;
			key_q[2] <= hcd_pkg::INV_KEY_ROW2_RST;
			key_q[3] <= hcd_pkg::INV_KEY_ROW3_RST;
		end else if (cfg_we) begin
			unique case (hcd_pkg::cfg_reg_t'(cfg_index))
				hcd_pkg::REG_INV_KEY_ROW0: key_q[0] <= cfg_wdata;
				hcd_pkg::REG_INV_KEY_ROW1: key_q[1] <= cfg_wdata;
				hcd_pkg::REG_INV_KEY_ROW2: key_q[2] <= cfg_wdata;
				hcd_pkg::REG_INV_KEY_ROW3: key_q[3] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	hcd_block_math u_math (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.char_in   (cipher.cipher_char),
		.key       (key_q),
		.stat      (stat),
		.grp_valid (grp_valid),
		.grp       (grp)
	);

	hcd_result_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.grp_valid (grp_valid),
		.grp       (grp),
		.count     (q_count),
		.plain     (plain)
	);

endmodule
